### rtl/glcm_pkg.sv
// ----------------------------------------------------------------------------
// glcm_pkg
// Shared constants, opcodes and sequencer states of the co-occurrence block.
// ----------------------------------------------------------------------------
package glcm_pkg;

    localparam int GRAY_LEVELS_DEF = 256;
    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int COUNT_BITS_DEF  = 32;

    localparam int          CFG_W         = 13;
    localparam logic [12:0] WIDTH_RESET   = 13'd640;
    localparam int          FRAC_BITS     = 16;
    localparam int          PROB_W        = FRAC_BITS + 1;
    localparam int          OUT_W         = 32;

    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_READ,
        ST_PIX_UPDATE,
        ST_DIAG_WRITE,
        ST_RD_READ,
        ST_RD_LATCH,
        ST_DIV
    } state_t;

endpackage

### rtl/glcm_cooccurrence_accumulator.sv
// ----------------------------------------------------------------------------
// glcm_cooccurrence_accumulator
// Gray-level co-occurrence counts for horizontal and 45-degree neighbors.
// ----------------------------------------------------------------------------
// Usage: pixels enter on the s_ channel in raster order (opcode pixel); the
// row length comes from the cfg_w write channel. A read beat returns one
// entry count, the table pair total and the Q1.16 probability on the m_
// channel. A clear beat zeroes both tables, both totals and the raster
// position; it gives no result.
// Flow: s_ready is high only while the sequencer is idle. A pixel does a
// read-modify-write of both tables through single-port RAMs. A read passes
// through the table read and the bit-serial divider (operand load plus 16
// quotient bits), after which the result loads into the output register.
// Reset and clear: a sweep writes zero to all GRAY_LEVELS^2 entries of both
// tables, one address per cycle; no beat is accepted meanwhile. Config
// writes are taken at any time.
// Stall: a finished result waits in the divider until the output register
// is free; the block then returns to idle.
// ----------------------------------------------------------------------------
module glcm_cooccurrence_accumulator #(
    parameter int GRAY_LEVELS = glcm_pkg::GRAY_LEVELS_DEF,
    parameter int MAX_WIDTH   = glcm_pkg::MAX_WIDTH_DEF,
    parameter int COUNT_BITS  = glcm_pkg::COUNT_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wvalid,
    output logic                         cfg_wready,
    input  logic [glcm_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_opcode,
    input  logic [7:0]                   s_pixel,
    input  logic [7:0]                   s_ref_level,
    input  logic [7:0]                   s_neighbor_level,
    input  logic                         s_table_select,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [glcm_pkg::OUT_W-1:0]   m_pair_count,
    output logic [glcm_pkg::OUT_W-1:0]   m_pair_total,
    output logic [glcm_pkg::PROB_W-1:0]  m_probability
);

    localparam int LW     = (GRAY_LEVELS > 1) ? $clog2(GRAY_LEVELS) : 1;
    localparam int TAB_D  = GRAY_LEVELS * GRAY_LEVELS;
    localparam int TAB_AW = $clog2(TAB_D);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    glcm_pkg::state_t state_reg, state_next;

    logic [glcm_pkg::CFG_W-1:0] width_reg;
    logic [LW-1:0]          px_reg, px_next, left_reg, left_next, up_reg, up_next;
    logic [CW-1:0]          col_pos_reg, col_pos_next, c_reg, c_next;
    logic [WW-1:0]          w_reg, w_next;
    logic                   past_reg, past_next;
    logic [COUNT_BITS-1:0]  htot_reg, htot_next, dtot_reg, dtot_next;
    logic [TAB_AW-1:0]      clr_reg, clr_next;
    logic [7:0]             rl_reg, rl_next, nl_reg, nl_next;
    logic                   sel_reg, sel_next;
    logic [COUNT_BITS-1:0]  cnt_reg, cnt_next, tot_reg, tot_next;
    logic                   m_valid_reg, m_valid_next;
    logic [glcm_pkg::OUT_W-1:0]  oc_reg, oc_next, ot_reg, ot_next;
    logic [glcm_pkg::PROB_W-1:0] op_reg, op_next;

    logic                   h_we, d_we, r_we;
    logic [TAB_AW-1:0]      h_addr, d_addr;
    logic [CW-1:0]          r_addr;
    logic [COUNT_BITS-1:0]  h_wdata, d_wdata, h_rdata, d_rdata;
    logic [LW-1:0]          r_rdata;

    logic                   div_start, div_busy;
    logic [glcm_pkg::PROB_W-1:0] div_quot;

    logic [31:0]            w_raw;
    logic [WW-1:0]          w_eff;
    logic [7:0]             px_sat;
    logic [WW-1:0]          c_inc;
    logic                   c_last, diag_en, rd_in_range;
    logic [63:0]            cnt_wide, tot_wide;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic logic [TAB_AW-1:0] pair_addr(input logic [LW-1:0] a,
                                                     input logic [LW-1:0] b);
        return TAB_AW'(a) * TAB_AW'(GRAY_LEVELS) + TAB_AW'(b);
    endfunction

    glcm_ram #(.WIDTH(COUNT_BITS), .DEPTH(TAB_D)) u_hram (
        .aclk(aclk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata)
    );

    glcm_ram #(.WIDTH(COUNT_BITS), .DEPTH(TAB_D)) u_dram (
        .aclk(aclk), .we(d_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_rdata)
    );

    glcm_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_row (
        .aclk(aclk), .we(r_we), .addr(r_addr), .wdata(px_reg), .rdata(r_rdata)
    );

    // operands come straight from the latch values so the divider starts with them
    glcm_div #(.COUNT_BITS(COUNT_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .count(cnt_next), .total(tot_next), .busy(div_busy), .quot(div_quot)
    );

    // clamp width to the supported range
    always_comb begin
        w_raw = 32'(width_reg);
        if (w_raw < 32'd2) begin
            w_eff = WW'(2);
        end else if (w_raw > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(w_raw);
        end
        px_sat = (32'(s_pixel) >= 32'(GRAY_LEVELS)) ? 8'(GRAY_LEVELS - 1) : s_pixel;
    end

    assign c_inc       = WW'(c_reg) + WW'(1);
    assign c_last      = c_inc >= w_reg;
    assign diag_en     = past_reg && !c_last;
    assign rd_in_range = (32'(rl_reg) < 32'(GRAY_LEVELS))
                      && (32'(nl_reg) < 32'(GRAY_LEVELS));

    always_comb begin
        state_next   = state_reg;
        px_next      = px_reg;
        left_next    = left_reg;
        up_next      = up_reg;
        col_pos_next = col_pos_reg;
        c_next       = c_reg;
        w_next       = w_reg;
        past_next    = past_reg;
        htot_next    = htot_reg;
        dtot_next    = dtot_reg;
        clr_next     = clr_reg;
        rl_next      = rl_reg;
        nl_next      = nl_reg;
        sel_next     = sel_reg;
        cnt_next     = cnt_reg;
        tot_next     = tot_reg;
        m_valid_next = m_valid_reg && !m_ready;
        oc_next      = oc_reg;
        ot_next      = ot_reg;
        op_next      = op_reg;
        h_we         = 1'b0;
        d_we         = 1'b0;
        r_we         = 1'b0;
        h_addr       = pair_addr(left_reg, px_reg);
        d_addr       = pair_addr(px_reg, up_reg);
        r_addr       = CW'(c_inc);
        h_wdata      = sat_inc(h_rdata);
        d_wdata      = sat_inc(d_rdata);
        div_start    = 1'b0;
        s_ready      = 1'b0;

        unique case (state_reg)
            glcm_pkg::ST_CLEAR: begin
                h_we    = 1'b1;
                d_we    = 1'b1;
                h_addr  = clr_reg;
                d_addr  = clr_reg;
                h_wdata = '0;
                d_wdata = '0;
                clr_next = clr_reg + TAB_AW'(1);
                if (clr_reg == TAB_AW'(TAB_D - 1)) begin
                    state_next = glcm_pkg::ST_IDLE;
                end
            end
            glcm_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    px_next  = LW'(px_sat);
                    rl_next  = s_ref_level;
                    nl_next  = s_neighbor_level;
                    sel_next = s_table_select;
                    w_next   = w_eff;
                    c_next   = (WW'(col_pos_reg) >= w_eff) ? CW'(w_eff - WW'(1))
                                                           : col_pos_reg;
                    unique case (s_opcode)
                        glcm_pkg::OP_PIXEL: state_next = glcm_pkg::ST_PIX_READ;
                        glcm_pkg::OP_READ:  state_next = glcm_pkg::ST_RD_READ;
                        glcm_pkg::OP_CLEAR: begin
                            state_next   = glcm_pkg::ST_CLEAR;
                            clr_next     = '0;
                            htot_next    = '0;
                            dtot_next    = '0;
                            left_next    = '0;
                            col_pos_next = '0;
                            past_next    = 1'b0;
                        end
                        default: state_next = glcm_pkg::ST_IDLE;
                    endcase
                end
            end
            glcm_pkg::ST_PIX_READ: begin
                state_next = glcm_pkg::ST_PIX_UPDATE;
            end
            glcm_pkg::ST_PIX_UPDATE: begin
                // horizontal pair, line buffer write, fetch the diagonal entry
                h_we    = c_reg != '0;
                r_we    = 1'b1;
                r_addr  = c_reg;
                d_addr  = pair_addr(px_reg, r_rdata);
                up_next = r_rdata;
                if (c_reg != '0) begin
                    htot_next = sat_inc(htot_reg);
                end
                state_next = glcm_pkg::ST_DIAG_WRITE;
            end
            glcm_pkg::ST_DIAG_WRITE: begin
                d_we = diag_en;
                if (diag_en) begin
                    dtot_next = sat_inc(dtot_reg);
                end
                left_next = px_reg;
                if (c_last) begin
                    col_pos_next = '0;
                    past_next    = 1'b1;
                end else begin
                    col_pos_next = CW'(c_inc);
                end
                state_next = glcm_pkg::ST_IDLE;
            end
            glcm_pkg::ST_RD_READ: begin
                h_addr = pair_addr(LW'(rl_reg), LW'(nl_reg));
                d_addr = h_addr;
                state_next = glcm_pkg::ST_RD_LATCH;
            end
            glcm_pkg::ST_RD_LATCH: begin
                cnt_next  = rd_in_range ? (sel_reg ? d_rdata : h_rdata) : '0;
                tot_next  = sel_reg ? dtot_reg : htot_reg;
                div_start = 1'b1;
                state_next = glcm_pkg::ST_DIV;
            end
            glcm_pkg::ST_DIV: begin
                // hold until the divider is done and the output register is free
                if (!div_busy && (!m_valid_reg || m_ready)) begin
                    m_valid_next = 1'b1;
                    oc_next = (cnt_wide > 64'hFFFF_FFFF) ? '1 : cnt_wide[31:0];
                    ot_next = (tot_wide > 64'hFFFF_FFFF) ? '1 : tot_wide[31:0];
                    op_next = (tot_reg == '0) ? '0 : div_quot;
                    state_next = glcm_pkg::ST_IDLE;
                end
            end
            default: state_next = glcm_pkg::ST_IDLE;
        endcase
    end

    // widen count and total for the clip to the 32-bit result fields
    always_comb begin
        cnt_wide = 64'(cnt_reg);
        tot_wide = 64'(tot_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= glcm_pkg::ST_CLEAR;
            width_reg   <= glcm_pkg::WIDTH_RESET;
            left_reg    <= '0;
            col_pos_reg <= '0;
            past_reg    <= 1'b0;
            htot_reg    <= '0;
            dtot_reg    <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_wvalid) begin
                width_reg <= cfg_wdata;
            end
            left_reg    <= left_next;
            col_pos_reg <= col_pos_next;
            past_reg    <= past_next;
            htot_reg    <= htot_next;
            dtot_reg    <= dtot_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
        px_reg  <= px_next;
        up_reg  <= up_next;
        c_reg   <= c_next;
        w_reg   <= w_next;
        rl_reg  <= rl_next;
        nl_reg  <= nl_next;
        sel_reg <= sel_next;
        cnt_reg <= cnt_next;
        tot_reg <= tot_next;
        oc_reg  <= oc_next;
        ot_reg  <= ot_next;
        op_reg  <= op_next;
    end

    assign cfg_wready    = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_pair_count  = oc_reg;
    assign m_pair_total  = ot_reg;
    assign m_probability = op_reg;

endmodule

### rtl/glcm_ram.sv
// ----------------------------------------------------------------------------
// glcm_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module glcm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/glcm_div.sv
// ----------------------------------------------------------------------------
// glcm_div
// Restoring divider: count * 2^16 / total, one quotient bit per cycle.
// Assumes count <= total, so the integer part is a single bit.
// ----------------------------------------------------------------------------
module glcm_div #(
    parameter int COUNT_BITS = glcm_pkg::COUNT_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [COUNT_BITS-1:0]        count,
    input  logic [COUNT_BITS-1:0]        total,
    output logic                         busy,
    output logic [glcm_pkg::PROB_W-1:0]  quot
);

    localparam int STEP_W = $clog2(glcm_pkg::FRAC_BITS + 1);

    logic [COUNT_BITS-1:0]         rem_reg, rem_next;
    logic [COUNT_BITS-1:0]         dvs_reg, dvs_next;
    logic [glcm_pkg::PROB_W-1:0]   quot_reg, quot_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic [COUNT_BITS:0]           shifted;
    logic                          take;

    always_comb begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        shifted   = {rem_reg, 1'b0};
        take      = shifted >= {1'b0, dvs_reg};
        if (start) begin
            dvs_next = total;
            if (count >= total) begin
                rem_next  = count - total;
                quot_next = glcm_pkg::PROB_W'(1);
            end else begin
                rem_next  = count;
                quot_next = '0;
            end
            step_next = STEP_W'(glcm_pkg::FRAC_BITS);
        end else if (step_reg != '0) begin
            rem_next  = take ? COUNT_BITS'(shifted - {1'b0, dvs_reg}) : COUNT_BITS'(shifted);
            quot_next = {quot_reg[glcm_pkg::PROB_W-2:0], take};
            step_next = step_reg - STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else begin
            step_reg <= step_next;
        end
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
    end

    assign busy = step_reg != '0;
    assign quot = quot_reg;

endmodule

### tb/glcm_cooccurrence_accumulator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcm_cooccurrence_accumulator_test
// Streams raster pixels, table reads, clears and unused opcodes into the
// co-occurrence block. A local model of both count tables predicts every
// read result. Widths cover the clamped extremes and a mid-row shrink.
// Gaps and stalls on both channels, plus a long output hold-off.
// ----------------------------------------------------------------------------
module glcm_cooccurrence_accumulator_test;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         LINE_MAX  = 4096;

    typedef struct packed {
        logic [glcm_pkg::OUT_W-1:0]  pair_count;
        logic [glcm_pkg::OUT_W-1:0]  pair_total;
        logic [glcm_pkg::PROB_W-1:0] probability;
    } entry_read_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wvalid = 1'b0;
    logic                          cfg_wready;
    logic [glcm_pkg::CFG_W-1:0]    cfg_wdata = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [1:0]                    s_opcode = glcm_pkg::OP_PIXEL;
    logic [7:0]                    s_pixel = '0;
    logic [7:0]                    s_ref_level = '0;
    logic [7:0]                    s_neighbor_level = '0;
    logic                          s_table_select = 1'b0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [glcm_pkg::OUT_W-1:0]    m_pair_count;
    logic [glcm_pkg::OUT_W-1:0]    m_pair_total;
    logic [glcm_pkg::PROB_W-1:0]   m_probability;

    always #5 aclk = ~aclk;

    glcm_cooccurrence_accumulator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wvalid(cfg_wvalid), .cfg_wready(cfg_wready), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_pixel(s_pixel), .s_ref_level(s_ref_level),
        .s_neighbor_level(s_neighbor_level), .s_table_select(s_table_select),
        .m_valid(m_valid), .m_ready(m_ready), .m_pair_count(m_pair_count),
        .m_pair_total(m_pair_total), .m_probability(m_probability)
    );

    // shadow of the block state
    bit [31:0]    horiz_cnt[int];
    bit [31:0]    diag_cnt[int];
    bit [7:0]     line_buf[LINE_MAX];
    bit [7:0]     prev_px;
    int           col;
    bit           second_row;
    bit [31:0]    horiz_sum;
    bit [31:0]    diag_sum;
    bit [glcm_pkg::CFG_W-1:0] width_reg;

    entry_read_t  read_q[$];
    int           errors;
    int           beats_sent;
    int           reads_checked;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_left;
    bit           hold_req;

    function automatic bit [31:0] sat_up(bit [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic void shadow_clear();
        horiz_cnt.delete();
        diag_cnt.delete();
        horiz_sum = 0;
        diag_sum = 0;
        prev_px = 0;
        col = 0;
        second_row = 0;
    endfunction

    function automatic void shadow_pixel(bit [7:0] px);
        int w;
        int c;
        int up_idx;
        w = int'(width_reg);
        c = col;
        if (w < 2) w = 2;
        if (w > LINE_MAX) w = LINE_MAX;
        if (c >= w) c = w - 1;
        if (c > 0) begin
            horiz_cnt[{prev_px, px}] = sat_up(horiz_cnt.exists({prev_px, px}) ?
                                              horiz_cnt[{prev_px, px}] : 0);
            horiz_sum = sat_up(horiz_sum);
        end
        if (second_row && c + 1 < w) begin
            up_idx = {px, line_buf[c + 1]};
            diag_cnt[up_idx] = sat_up(diag_cnt.exists(up_idx) ? diag_cnt[up_idx] : 0);
            diag_sum = sat_up(diag_sum);
        end
        line_buf[c] = px;
        prev_px = px;
        if (c + 1 >= w) begin
            col = 0;
            second_row = 1;
        end else begin
            col = c + 1;
        end
    endfunction

    function automatic entry_read_t shadow_read(bit [7:0] rl, bit [7:0] nl, bit sel);
        entry_read_t r;
        longint unsigned cnt;
        longint unsigned tot;
        longint unsigned prob;
        int idx;
        idx = {rl, nl};
        if (sel) begin
            cnt = diag_cnt.exists(idx) ? diag_cnt[idx] : 0;
            tot = diag_sum;
        end else begin
            cnt = horiz_cnt.exists(idx) ? horiz_cnt[idx] : 0;
            tot = horiz_sum;
        end
        prob = 0;
        if (tot != 0) begin
            prob = (cnt * 65536) / tot;
            if (prob > 65536) prob = 65536;
        end
        r.pair_count = glcm_pkg::OUT_W'(cnt);
        r.pair_total = glcm_pkg::OUT_W'(tot);
        r.probability = glcm_pkg::PROB_W'(prob);
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // one beat on the input channel; predictor runs at acceptance
    task automatic send_beat(logic [1:0] op, logic [7:0] px, logic [7:0] rl,
                             logic [7:0] nl, logic sel);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_pixel <= px;
        s_ref_level <= rl;
        s_neighbor_level <= nl;
        s_table_select <= sel;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        case (op)
            glcm_pkg::OP_PIXEL: shadow_pixel(px);
            glcm_pkg::OP_CLEAR: shadow_clear();
            glcm_pkg::OP_READ:  read_q.push_back(shadow_read(rl, nl, sel));
            default: ;
        endcase
    endtask

    task automatic pixel(logic [7:0] px);
        send_beat(glcm_pkg::OP_PIXEL, px, 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic read_entry(logic [7:0] rl, logic [7:0] nl, logic sel);
        send_beat(glcm_pkg::OP_READ, 8'($urandom), rl, nl, sel);
    endtask

    // drop valid, wait for all results and for the sequencer to go idle
    task automatic settle();
        s_valid <= 1'b0;
        while (read_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic set_width(logic [glcm_pkg::CFG_W-1:0] w, bit with_clear);
        settle();
        cfg_wvalid <= 1'b1;
        cfg_wdata <= w;
        do @(posedge aclk); while (!cfg_wready);
        width_reg = w;
        cfg_wvalid <= 1'b0;
        if (with_clear) begin
            send_beat(glcm_pkg::OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                      1'($urandom));
        end
    endtask

    // small level pool most of the time so reads hit nonzero entries
    function automatic logic [7:0] pick_level();
        return ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(5));
    endfunction

    task automatic random_beat();
        int roll;
        roll = $urandom_range(99);
        if (roll < 65) pixel(pick_level());
        else if (roll < 97) read_entry(pick_level(), pick_level(), 1'($urandom));
        else send_beat(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // result check
    always @(posedge aclk) begin
        entry_read_t want;
        if (aresetn && m_valid && m_ready) begin
            if (read_q.size() == 0) begin
                $display("ERROR %0t: result beat with nothing pending", $realtime);
                errors++;
            end else begin
                want = read_q.pop_front();
                reads_checked++;
                if (m_pair_count !== want.pair_count)
                    report("pair_count", m_pair_count, want.pair_count);
                if (m_pair_total !== want.pair_total)
                    report("pair_total", m_pair_total, want.pair_total);
                if (m_probability !== want.probability)
                    report("probability", m_probability, want.probability);
            end
        end
    end

    // receiver: random stalls, plus a counted hold-off on request
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = 400;
            hold_req = 0;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic test_directed();
        set_width(4, 1'b0);
        read_entry(0, 0, 0);
        pixel(0); pixel(255); pixel(255); pixel(0);
        pixel(255); pixel(0); pixel(128); pixel(1);
        read_entry(0, 255, 0);
        read_entry(255, 255, 0);
        read_entry(255, 255, 1);
        read_entry(0, 255, 1);
        read_entry(128, 0, 1);
        read_entry(7, 9, 0);
        send_beat(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_beat(glcm_pkg::OP_CLEAR, 0, 0, 0, 0);
        read_entry(255, 255, 0);
        read_entry(255, 255, 1);
    endtask

    task automatic test_width_limits();
        // zero and one behave as two
        set_width(0, 1'b1);
        repeat (8) pixel(8'($urandom_range(3)));
        read_entry(0, 1, 0);
        read_entry(1, 1, 1);
        set_width(1, 1'b0);
        repeat (6) pixel(8'($urandom_range(3)));
        read_entry(2, 3, 1);
        // above the line buffer size clamps to it
        set_width(8191, 1'b1);
        repeat (10) pixel(8'h5A);
        read_entry(8'h5A, 8'h5A, 0);
        set_width(2, 1'b1);
        repeat (5) pixel(8'($urandom_range(1)));
        read_entry(1, 0, 1);
        // shrink mid-row: a column past the new end closes the row
        set_width(8, 1'b1);
        repeat (11) pixel(pick_level());
        set_width(3, 1'b0);
        repeat (9) pixel(pick_level());
        read_entry(0, 1, 1);
        read_entry(2, 2, 0);
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int n);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        set_width(glcm_pkg::CFG_W'($urandom_range(2, 40)), 1'b1);
        repeat (n) random_beat();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1;
        repeat (20) read_entry(pick_level(), pick_level(), 1'($urandom));
        // pause input until every result is back, then resume
        s_valid <= 1'b0;
        while (read_q.size() != 0) @(posedge aclk);
        repeat (20) random_beat();
    endtask

    initial begin
        shadow_clear();
        width_reg = glcm_pkg::WIDTH_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_width_limits();
        test_random_phase(0, 0, 200);
        test_random_phase(53, 0, 200);
        test_random_phase(0, 53, 200);
        test_random_phase(33, 33, 200);
        test_backpressure();
        settle();
        repeat (50) @(posedge aclk);
        $display("Covered %0d input beats and %0d checked reads over several widths,",
                 beats_sent, reads_checked);
        $display("clears, unused opcodes, idle and stall mixes and a long hold-off.");
        if (errors == 0 && read_q.size() == 0) begin
            $display("glcm_cooccurrence_accumulator: match");
        end else begin
            $display("glcm_cooccurrence_accumulator: mismatch");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("glcm_cooccurrence_accumulator: mismatch");
        $finish;
    end

endmodule
